// ===== sv/ile_pkg.sv =====
// ile_pkg: operation and status codes, command and status structs shared
// by the indexed list engine controller, datapath and top level.
// No dependencies.
package ile_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_FIND       = 3'd6
  } op_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [6:0]  FOUND_NONE  = 7'h7F;
  localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    K_NONE   = 2'd0,
    K_INSERT = 2'd1,
    K_REMOVE = 2'd2,
    K_FIND   = 2'd3
  } kind_t;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic shift_rd;
    logic put;
    logic cnt_inc;
    logic cnt_dec;
    logic search_rd;
    logic found_set;
    logic not_found;
    logic rd_front;
    logic rd_back;
    logic cap_back;
    logic load;
  } ile_cmd_t;

  typedef struct packed {
    logic  in_valid;
    kind_t dec_kind;
    logic  dec_shift;
    logic  shift_last;
    logic  search_match;
    logic  search_last;
    logic  ptr_end;
    logic  out_free;
  } ile_stat_t;

endpackage

// ===== sv/ile_ifs.sv =====
// ile_req_if / ile_rsp_if: valid/ready channels carrying one request item
// and one result item of the indexed list engine. No dependencies.
interface ile_req_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  operation;
  logic        [7:0]  position;
  logic signed [31:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

interface ile_rsp_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic signed [6:0]  found_position;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic        [6:0]  element_total;
  logic               is_empty;

  modport source (output valid, status, found_position, front_value, back_value,
                  element_total, is_empty, input ready);
  modport sink   (input valid, status, found_position, front_value, back_value,
                  element_total, is_empty, output ready);
endinterface

// ===== sv/ile_ram.sv =====
// ile_ram: generic one-write, one-read RAM with registered read data.
// A read at the address being written returns the old contents.
module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ile_ctrl.sv =====
// ile_ctrl: sequencer of the indexed list engine. Walks each item through
// shift, put, search and front/back read phases. Uses ile_pkg.
module ile_ctrl
  import ile_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ile_stat_t stat,
  output ile_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_SEARCH,
    S_RD_FRONT,
    S_RD_BACK,
    S_CAP_BACK,
    S_FINISH
  } state_t;

  state_t state, state_next;
  kind_t  kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= K_NONE;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    kind_next  = kind;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.accept = 1'b1;
          kind_next  = stat.dec_kind;
          unique case (stat.dec_kind)
            K_INSERT: state_next = stat.dec_shift ? S_SHIFT : S_PUT;
            K_REMOVE: state_next = stat.dec_shift ? S_SHIFT : S_DRAIN;
            K_FIND:   state_next = S_SEARCH;
            K_NONE:   state_next = S_RD_FRONT;
          endcase
        end
      end
      S_SHIFT: begin
        cmd.shift_rd = 1'b1;
        if (stat.shift_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (kind == K_INSERT) begin
          state_next = S_PUT;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_RD_FRONT;
        end
      end
      S_PUT: begin
        cmd.put     = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = S_RD_FRONT;
      end
      S_SEARCH: begin
        priority if (stat.search_match) begin
          cmd.found_set = 1'b1;
          state_next    = S_RD_FRONT;
        end else if (stat.search_last) begin
          cmd.not_found = 1'b1;
          state_next    = S_RD_FRONT;
        end else if (!stat.ptr_end) begin
          cmd.search_rd = 1'b1;
        end
      end
      S_RD_FRONT: begin
        cmd.rd_front = 1'b1;
        state_next   = S_RD_BACK;
      end
      S_RD_BACK: begin
        cmd.rd_back = 1'b1;
        state_next  = S_CAP_BACK;
      end
      S_CAP_BACK: begin
        cmd.cap_back = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/ile_dp.sv =====
// ile_dp: datapath of the indexed list engine: operation decode, element
// RAM (ile_ram), shift/search pointer, count and result register.
// Uses ile_pkg, ile_req_if, ile_rsp_if.
module ile_dp
  import ile_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  ile_req_if.sink    req,
  ile_rsp_if.source  rsp,
  input  ile_cmd_t   cmd,
  output ile_stat_t  stat
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 8) ? CW : 8;

  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [CW-1:0] idx;
  logic          ins;
  logic [31:0]   value;
  logic          wr_pend;
  logic [AW-1:0] wr_addr;
  logic          cmp_pend;
  logic [CW-1:0] cmp_addr;
  logic [2:0]    res_status;
  logic [6:0]    res_found;
  logic [31:0]   front_q;
  logic [31:0]   back_q;
  logic          out_valid;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  kind_t         dec_kind;
  logic [2:0]    dec_status;
  logic [CW-1:0] dec_idx;
  logic          dec_shift;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic          full;
  logic          empty;
  logic [CW-1:0] ptr_inc;
  logic [CW-1:0] ptr_dec;
  logic [CW-1:0] cnt_last;

  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign pos_x    = XW'(req.position);
  assign cnt_x    = XW'(count);
  assign ptr_inc  = ptr + CW'(1);
  assign ptr_dec  = ptr - CW'(1);
  assign cnt_last = count - CW'(1);

  always_comb begin
    dec_kind   = K_NONE;
    dec_status = ST_OK;
    dec_idx    = '0;
    case (req.operation)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_kind = K_INSERT;
          dec_idx  = (req.operation == OP_PUSH_FRONT) ? '0 : count;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_kind = K_REMOVE;
          dec_idx  = (req.operation == OP_POP_FRONT) ? '0 : cnt_last;
        end
      end
      OP_INSERT: begin
        priority if (full) begin
          dec_status = ST_FULL;
        end else if (empty || req.position == '0) begin
          dec_kind = K_INSERT;
        end else if (pos_x >= cnt_x - XW'(1)) begin
          dec_kind = K_INSERT;
          dec_idx  = count;
        end else begin
          dec_kind = K_INSERT;
          dec_idx  = CW'(pos_x);
        end
      end
      OP_REMOVE: begin
        priority if (empty) begin
          dec_status = ST_EMPTY;
        end else if (pos_x > cnt_x - XW'(1)) begin
          dec_status = ST_RANGE;
        end else begin
          dec_kind = K_REMOVE;
          dec_idx  = CW'(pos_x);
        end
      end
      OP_FIND: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_kind = K_FIND;
        end
      end
      default: dec_kind = K_NONE;
    endcase
  end

  always_comb begin
    unique case (dec_kind)
      K_INSERT: dec_shift = (dec_idx < count);
      K_REMOVE: dec_shift = ((dec_idx + CW'(1)) < count);
      default:  dec_shift = 1'b0;
    endcase
  end

  always_comb begin
    priority if (cmd.shift_rd || cmd.search_rd) begin
      ram_raddr = ptr[AW-1:0];
    end else if (cmd.rd_back) begin
      ram_raddr = cnt_last[AW-1:0];
    end else if (cmd.rd_front) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = '0;
    end
  end

  assign ram_we    = wr_pend || cmd.put;
  assign ram_waddr = cmd.put ? idx[AW-1:0] : wr_addr;
  assign ram_wdata = cmd.put ? value : ram_rdata;

  ile_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      wr_pend   <= 1'b0;
      cmp_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      wr_pend  <= cmd.shift_rd;
      cmp_pend <= cmd.search_rd;
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= cnt_last;
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ins        <= (dec_kind == K_INSERT);
      idx        <= dec_idx;
      value      <= req.value;
      res_status <= dec_status;
      res_found  <= FOUND_NONE;
      unique case (dec_kind)
        K_INSERT: ptr <= cnt_last;
        K_REMOVE: ptr <= dec_idx + CW'(1);
        default:  ptr <= '0;
      endcase
    end else if (cmd.shift_rd) begin
      ptr     <= ins ? ptr_dec : ptr_inc;
      wr_addr <= ins ? ptr_inc[AW-1:0] : ptr_dec[AW-1:0];
    end else if (cmd.search_rd) begin
      ptr      <= ptr_inc;
      cmp_addr <= ptr;
    end
    if (cmd.found_set) begin
      res_found <= 7'(cmp_addr);
    end
    if (cmd.not_found) begin
      res_status <= ST_NOTFOUND;
    end
    if (cmd.rd_back) begin
      front_q <= ram_rdata;
    end
    if (cmd.cap_back) begin
      back_q <= ram_rdata;
    end
    if (cmd.load) begin
      rsp.status         <= res_status;
      rsp.found_position <= res_found;
      rsp.front_value    <= empty ? EMPTY_VALUE : front_q;
      rsp.back_value     <= empty ? EMPTY_VALUE : back_q;
      rsp.element_total  <= 7'(count);
      rsp.is_empty       <= empty;
    end
  end

  assign rsp.valid = out_valid;
  assign req.ready = cmd.in_ready;

  assign stat.in_valid     = req.valid;
  assign stat.dec_kind     = dec_kind;
  assign stat.dec_shift    = dec_shift;
  assign stat.shift_last   = ins ? (ptr == idx) : (ptr == cnt_last);
  assign stat.search_match = cmp_pend && (ram_rdata == value);
  assign stat.search_last  = cmp_pend && (cmp_addr == cnt_last);
  assign stat.ptr_end      = (ptr == count);
  assign stat.out_free     = !out_valid || rsp.ready;

endmodule

// ===== sv/indexed_list_engine.sv =====
// indexed_list_engine: bounded ordered list of signed 32-bit values with
// push/pop at both ends, indexed insert/remove and find.
// Depends on ile_pkg, ile_ifs (ile_req_if, ile_rsp_if), ile_ctrl, ile_dp.
//
//   channel  direction  fields
//   req      in         operation, position, value
//   rsp      out        status, found_position, front_value, back_value,
//                       element_total, is_empty
//
// One item at a time; an element move is a RAM read and a RAM write, and a
// compare is a RAM read. Each item passes through accept, front read, back read,
// capture and load; between accept and front read, insert and remove may add
// element moves, and find adds compares up to the first match or the last element.
// Synchronous reset empties the list; RAM contents are not cleared.
// req is taken again once the result is loaded, while it waits on rsp.
module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst,
  ile_req_if.sink   req,
  ile_rsp_if.source rsp
);

  ile_cmd_t  cmd;
  ile_stat_t stat;

  ile_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  ile_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

// ===== sv/ile_checker.sv =====
// ile_checker: port-level assertions on indexed_list_engine results, bound
// to the top level. Uses ile_pkg.
module ile_checker
  import ile_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  rsp_status,
  input logic [6:0]  rsp_found_position,
  input logic [31:0] rsp_front_value,
  input logic [31:0] rsp_back_value,
  input logic [6:0]  rsp_element_total,
  input logic        rsp_is_empty
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_element_total))
    else $error("result item changed while stalled");

  a_total: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CAPACITY > 127) || (rsp_element_total <= 7'(CAPACITY)))
    else $error("element total above capacity");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_is_empty |-> rsp_element_total == '0
      && rsp_front_value == EMPTY_VALUE && rsp_back_value == EMPTY_VALUE)
    else $error("empty list result inconsistent");

  a_st_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EMPTY |-> rsp_is_empty)
    else $error("empty status on non-empty list");

  a_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found_position != FOUND_NONE |-> rsp_status == ST_OK)
    else $error("found position with failing status");

endmodule

bind indexed_list_engine ile_checker #(.CAPACITY(CAPACITY)) u_ile_checker (
  .clk                (clk),
  .rst                (rst),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_found_position (rsp.found_position),
  .rsp_front_value    (rsp.front_value),
  .rsp_back_value     (rsp.back_value),
  .rsp_element_total  (rsp.element_total),
  .rsp_is_empty       (rsp.is_empty)
);
